/* sv/assert_macros.svh */
// Assertion macros shared by the RPN operand stack RTL.
// Each macro expands to one labeled concurrent assertion with reset gating.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rpn_stk_pkg.sv */
// Shared types and constants of the RPN operand stack.
// No dependencies; used by every module of the block.
package rpn_stk_pkg;

  localparam int PORT_W      = 64;
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 264;

  typedef logic [3:0] opcode_t;

  localparam opcode_t OP_CLX      = 4'd0;
  localparam opcode_t OP_CLEAR    = 4'd1;
  localparam opcode_t OP_DROP     = 4'd2;
  localparam opcode_t OP_LIFT     = 4'd3;
  localparam opcode_t OP_DROPY    = 4'd4;
  localparam opcode_t OP_ROLLUP   = 4'd5;
  localparam opcode_t OP_ROLLDOWN = 4'd6;
  localparam opcode_t OP_SWAPXY   = 4'd7;
  localparam opcode_t OP_SHUFFLE  = 4'd8;
  localparam opcode_t OP_FILL     = 4'd9;
  localparam opcode_t OP_SAVE     = 4'd10;
  localparam opcode_t OP_UNDO     = 4'd11;

  typedef struct packed {
    logic [7:0]        shuffle_order;
    logic              lift_enabled;
    logic [PORT_W-1:0] value;
    opcode_t           opcode;
  } item_t;

  typedef struct packed {
    logic              undo_available;
    logic [PORT_W-1:0] level_t;
    logic [PORT_W-1:0] level_z;
    logic [PORT_W-1:0] level_y;
    logic [PORT_W-1:0] level_x;
  } result_t;

endpackage

/* sv/rpn_stk_in_stage.sv */
// Input register of the RPN operand stack: holds one accepted beat.
// Depends on rpn_stk_pkg.
module rpn_stk_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rpn_stk_pkg::item_t  in_item,
  input  logic                advance,
  output logic                item_valid,
  output rpn_stk_pkg::item_t  item
);
  import rpn_stk_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // Free when empty or when the held beat moves on this cycle.
  assign in_ready = !valid_r || advance;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* sv/rpn_stk_core.sv */
// Level and snapshot registers of the RPN operand stack with their
// next-state logic. Depends on rpn_stk_pkg.
module rpn_stk_core #(
  parameter int WORD_WIDTH = 64,
  parameter int MAX_LEVELS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 advance,
  input  rpn_stk_pkg::item_t   item,
  output rpn_stk_pkg::result_t res_nxt,
  output logic                 snap_valid
);
  import rpn_stk_pkg::*;

  typedef logic [WORD_WIDTH-1:0] word_t;

  word_t stack_r [MAX_LEVELS];
  word_t stack_nxt [MAX_LEVELS];
  word_t snap_r [MAX_LEVELS];
  word_t snap_nxt [MAX_LEVELS];
  logic  snap_valid_r, snap_valid_nxt;
  logic  eight_r, eight_nxt;

  word_t above [MAX_LEVELS];
  word_t below [MAX_LEVELS];
  logic  active [MAX_LEVELS];
  logic  is_top [MAX_LEVELS];
  word_t low4 [4];
  word_t shuf [4];
  word_t top_lvl;
  word_t value_w;

  assign value_w = item.value[WORD_WIDTH-1:0];
  assign top_lvl = eight_r ? stack_r[MAX_LEVELS-1] : stack_r[3];

  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_lvl
    if (i + 1 < MAX_LEVELS) begin : g_above
      assign above[i] = stack_r[i+1];
    end else begin : g_above_top
      assign above[i] = stack_r[i];
    end
    if (i > 0) begin : g_below
      assign below[i] = stack_r[i-1];
    end else begin : g_below_x
      assign below[i] = stack_r[i];
    end
    if (i < 4) begin : g_act_low
      assign active[i] = 1'b1;
    end else begin : g_act_high
      assign active[i] = eight_r;
    end
    if (i == 3 && i == MAX_LEVELS - 1) begin : g_top_both
      assign is_top[i] = 1'b1;
    end else if (i == 3) begin : g_top_four
      assign is_top[i] = !eight_r;
    end else if (i == MAX_LEVELS - 1) begin : g_top_max
      assign is_top[i] = eight_r;
    end else begin : g_top_none
      assign is_top[i] = 1'b0;
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_shuf
    assign low4[j] = stack_r[j];
    assign shuf[j] = low4[item.shuffle_order[2*j +: 2]];
  end

  always_comb begin
    eight_nxt = cfg_we ? cfg_wdata : eight_r;
  end

  always_comb begin
    stack_nxt      = stack_r;
    snap_nxt       = snap_r;
    snap_valid_nxt = snap_valid_r;
    case (item.opcode)
      OP_CLX: begin
        stack_nxt[0] = '0;
      end
      OP_CLEAR: begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
          if (active[i]) stack_nxt[i] = '0;
        end
      end
      OP_DROP: begin
        // The top level keeps its value.
        for (int i = 0; i < MAX_LEVELS; i++) begin
          if (active[i] && !is_top[i]) stack_nxt[i] = above[i];
        end
      end
      OP_LIFT: begin
        if (item.lift_enabled) begin
          for (int i = 1; i < MAX_LEVELS; i++) begin
            if (active[i]) stack_nxt[i] = below[i];
          end
        end
        stack_nxt[0] = value_w;
      end
      OP_DROPY: begin
        for (int i = 1; i < MAX_LEVELS; i++) begin
          if (active[i] && !is_top[i]) stack_nxt[i] = above[i];
        end
      end
      OP_ROLLUP: begin
        for (int i = 1; i < MAX_LEVELS; i++) begin
          if (active[i]) stack_nxt[i] = below[i];
        end
        stack_nxt[0] = top_lvl;
      end
      OP_ROLLDOWN: begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
          if (is_top[i]) begin
            stack_nxt[i] = stack_r[0];
          end else if (active[i]) begin
            stack_nxt[i] = above[i];
          end
        end
      end
      OP_SWAPXY: begin
        stack_nxt[0] = stack_r[1];
        stack_nxt[1] = stack_r[0];
      end
      OP_SHUFFLE: begin
        // Keep the old X..T in the snapshot; the valid flag stays as is.
        for (int j = 0; j < 4; j++) begin
          snap_nxt[j]  = stack_r[j];
          stack_nxt[j] = shuf[j];
        end
      end
      OP_FILL: begin
        for (int i = 1; i < MAX_LEVELS; i++) begin
          if (active[i]) stack_nxt[i] = stack_r[0];
        end
      end
      OP_SAVE: begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
          if (active[i]) snap_nxt[i] = stack_r[i];
        end
        snap_valid_nxt = 1'b1;
      end
      OP_UNDO: begin
        if (snap_valid_r) begin
          for (int i = 0; i < MAX_LEVELS; i++) begin
            if (active[i]) stack_nxt[i] = snap_r[i];
          end
          snap_valid_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        stack_r[i] <= '0;
        snap_r[i]  <= '0;
      end
      snap_valid_r <= 1'b0;
      eight_r      <= 1'b0;
    end else begin
      eight_r <= eight_nxt;
      if (advance) begin
        stack_r      <= stack_nxt;
        snap_r       <= snap_nxt;
        snap_valid_r <= snap_valid_nxt;
      end
    end
  end

  assign res_nxt.level_x        = PORT_W'(stack_nxt[0]);
  assign res_nxt.level_y        = PORT_W'(stack_nxt[1]);
  assign res_nxt.level_z        = PORT_W'(stack_nxt[2]);
  assign res_nxt.level_t        = PORT_W'(stack_nxt[3]);
  assign res_nxt.undo_available = snap_valid_nxt;
  assign snap_valid             = snap_valid_r;

endmodule

/* sv/rpn_operand_stack_top.sv */
// RPN operand stack of four or eight levels (X at the bottom) with an undo
// snapshot. Each input beat carries one opcode and produces one result beat
// with X, Y, Z, T and the undo flag. One beat is taken every cycle while the
// result side drains; a beat goes input register -> one pass of level update
// logic -> result register before its result is offered. The depth is set
// by the one-bit configuration register, which the user must write only while
// the block is idle; the block itself does not enforce this.
module rpn_operand_stack_top #(
  parameter int WORD_WIDTH = 64,
  parameter int MAX_LEVELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic                                 cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // value[63:0], lift_enabled[64], shuffle_order[72:65], zero fill above
  input  logic [rpn_stk_pkg::IN_TDATA_W-1:0]   in_tdata,
  // opcode[3:0]
  input  logic [rpn_stk_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // level_x[63:0], level_y[127:64], level_z[191:128], level_t[255:192],
  // undo_available[256], zero fill above
  output logic [rpn_stk_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import rpn_stk_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t res_nxt;
  result_t out_res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    snap_valid;
  logic    take_save, take_undo, take_clx;
  logic    x_zero;

  assign in_item.opcode        = in_tuser;
  assign in_item.value         = in_tdata[63:0];
  assign in_item.lift_enabled  = in_tdata[64];
  assign in_item.shuffle_order = in_tdata[72:65];

  // Move the held beat when the result register is free or being drained.
  assign advance = item_valid && (!out_valid_r || out_tready);

  rpn_stk_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  rpn_stk_core #(
    .WORD_WIDTH (WORD_WIDTH),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .advance    (advance),
    .item       (item),
    .res_nxt    (res_nxt),
    .snap_valid (snap_valid)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_res_r);

  assign take_save = advance && item.opcode == OP_SAVE;
  assign take_undo = advance && item.opcode == OP_UNDO;
  assign take_clx  = advance && item.opcode == OP_CLX;
  assign x_zero    = out_res_r.level_x == '0;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_save_sets_undo, clk, rst_n, take_save, snap_valid, "save did not arm undo")
  `ASSERT_NEXT(a_undo_clears, clk, rst_n, take_undo, !snap_valid, "undo left snapshot armed")
  `ASSERT_NEXT(a_clx_zero, clk, rst_n, take_clx, out_tvalid && x_zero, "clx result X not zero")
  `ASSERT_IMP(a_flag_match, clk, rst_n, out_tvalid, out_tdata[256] == snap_valid, "undo flag stale")

endmodule

/* dv/tb_rpn_operand_stack_top.sv */
// Self-checking bench for rpn_operand_stack_top: random and directed opcode beats,
// with the stack levels tracked by an in-bench model and checked beat by beat.
// Depends on rpn_stk_pkg and the RTL only.
module tb_rpn_operand_stack_top;
  import rpn_stk_pkg::*;

  localparam int LEVELS     = 8;
  localparam int HOLD_LEN   = 300;
  localparam int IDLE_LIMIT = 3000;
  localparam int RAND_PER_PHASE = 275;

  // Opcodes the block decodes as no-ops.
  localparam opcode_t OP_SPARE_FIRST = 4'd12;
  localparam opcode_t OP_SPARE_LAST  = 4'd15;

  class level_tracker;
    logic [PORT_W-1:0] lvl [LEVELS];
    logic [PORT_W-1:0] snap [LEVELS];
    bit                snap_ok;
    bit                eight;
    result_t           levels_due[$];
    int                errors;

    function new();
      foreach (lvl[i]) begin
        lvl[i]  = '0;
        snap[i] = '0;
      end
      snap_ok = 0;
      eight   = 0;
      errors  = 0;
    endfunction

    function void set_depth(bit e);
      eight = e;
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    function void report(string what, logic [PORT_W-1:0] got, logic [PORT_W-1:0] want);
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      errors++;
    endfunction

    // Apply one accepted beat to the tracked stack and queue the levels it leaves.
    function void note_beat(item_t it);
      int n;
      logic [PORT_W-1:0] tmp;
      logic [PORT_W-1:0] old [4];
      result_t r;
      n = eight ? LEVELS : 4;
      case (it.opcode)
        OP_CLX: lvl[0] = '0;
        OP_CLEAR: for (int i = 0; i < n; i++) lvl[i] = '0;
        OP_DROP: for (int i = 0; i < n - 1; i++) lvl[i] = lvl[i + 1];
        OP_LIFT: begin
          if (it.lift_enabled)
            for (int i = n - 1; i > 0; i--) lvl[i] = lvl[i - 1];
          lvl[0] = it.value;
        end
        OP_DROPY: for (int i = 1; i < n - 1; i++) lvl[i] = lvl[i + 1];
        OP_ROLLUP: begin
          tmp = lvl[n - 1];
          for (int i = n - 1; i > 0; i--) lvl[i] = lvl[i - 1];
          lvl[0] = tmp;
        end
        OP_ROLLDOWN: begin
          tmp = lvl[0];
          for (int i = 0; i < n - 1; i++) lvl[i] = lvl[i + 1];
          lvl[n - 1] = tmp;
        end
        OP_SWAPXY: begin
          tmp    = lvl[0];
          lvl[0] = lvl[1];
          lvl[1] = tmp;
        end
        OP_SHUFFLE: begin
          for (int i = 0; i < 4; i++) old[i] = lvl[i];
          for (int i = 0; i < 4; i++) begin
            snap[i] = old[i];
            lvl[i]  = old[it.shuffle_order[2*i +: 2]];
          end
        end
        OP_FILL: for (int i = 1; i < n; i++) lvl[i] = lvl[0];
        OP_SAVE: begin
          for (int i = 0; i < n; i++) snap[i] = lvl[i];
          snap_ok = 1;
        end
        OP_UNDO: begin
          if (snap_ok) begin
            for (int i = 0; i < n; i++) lvl[i] = snap[i];
            snap_ok = 0;
          end
        end
        default: ;
      endcase
      r.level_x        = lvl[0];
      r.level_y        = lvl[1];
      r.level_z        = lvl[2];
      r.level_t        = lvl[3];
      r.undo_available = snap_ok;
      levels_due.push_back(r);
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (levels_due.size() == 0) begin
        report("unexpected result beat, level_x", got.level_x, '0);
        return;
      end
      want = levels_due.pop_front();
      if (got.level_x !== want.level_x) report("level_x", got.level_x, want.level_x);
      if (got.level_y !== want.level_y) report("level_y", got.level_y, want.level_y);
      if (got.level_z !== want.level_z) report("level_z", got.level_z, want.level_z);
      if (got.level_t !== want.level_t) report("level_t", got.level_t, want.level_t);
      if (got.undo_available !== want.undo_available)
        report("undo_available", PORT_W'(got.undo_available), PORT_W'(want.undo_available));
    endfunction

    function void check_drained();
      if (levels_due.size() != 0)
        report("result beats never seen, count", PORT_W'(levels_due.size()), '0);
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic                   cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  level_tracker sb = new();
  bit           hold_req;

  rpn_operand_stack_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(4, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic item_t make_item(opcode_t op, logic [PORT_W-1:0] v, logic le,
                                      logic [7:0] order);
    item_t it;
    it.opcode        = op;
    it.value         = v;
    it.lift_enabled  = le;
    it.shuffle_order = order;
    return it;
  endfunction

  function automatic item_t rand_item();
    int r;
    int s;
    opcode_t op;
    logic [PORT_W-1:0] v;
    r = $urandom_range(99);
    if (r < 30) op = OP_LIFT;
    else if (r < 95) op = opcode_t'($urandom_range(OP_UNDO, OP_CLX));
    else op = opcode_t'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    s = $urandom_range(9);
    if (s == 0) v = '1;
    else if (s == 1) v = '0;
    else if (s == 2) v = PORT_W'($urandom_range(255));
    else v = {$urandom, $urandom};
    return make_item(op, v, $urandom_range(9) < 7, 8'($urandom));
  endfunction

  // Offer one beat and hold it until the block takes it; returns on the next falling edge.
  task automatic send_beat(item_t it);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - 73){1'b0}}, it.shuffle_order, it.lift_enabled, it.value};
    in_tuser  <= it.opcode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_with_gap(item_t it);
    int gap;
    send_beat(it);
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_depth(bit e);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= e;
    sb.set_depth(e);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Accept monitors: sample on the rising edge only.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_beat(item_t'({in_tdata[72:0], in_tuser}));
    if (rst_n && out_tvalid && out_tready)
      sb.check_beat(result_t'(out_tdata[256:0]));
  end

  // Result side backpressure, with one long hold on request.
  initial begin
    bit held;
    held       = 0;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(30, 1)) @(negedge clk);
        if (pick_gap() != 0) begin
          out_tready <= 1'b0;
          repeat (pick_gap() + 1) @(negedge clk);
        end
      end
    end
  end

  // Abort when neither side moves a beat for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) idle = 0;
      else idle++;
    end
    $display("tb_rpn_operand_stack_top: done, errors");
    $finish;
  end

  initial begin
    bit depth_plan [4];
    item_t directed[$];
    depth_plan = '{1'b0, 1'b1, 1'b0, 1'b1};
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed sequence: extremes, every opcode, undo with and without a snapshot.
    directed.push_back(make_item(OP_UNDO, '0, 1'b0, 8'h00));
    directed.push_back(make_item(OP_LIFT, '1, 1'b0, 8'h00));
    directed.push_back(make_item(OP_LIFT, 64'h8000_0000_0000_0001, 1'b1, 8'hff));
    directed.push_back(make_item(OP_LIFT, 64'h0123_4567_89ab_cdef, 1'b1, 8'h00));
    directed.push_back(make_item(OP_LIFT, 64'hfedc_ba98_7654_3210, 1'b1, 8'h00));
    directed.push_back(make_item(OP_LIFT, 64'h0000_0000_0000_0005, 1'b1, 8'h00));
    directed.push_back(make_item(OP_SAVE, '0, 1'b0, 8'h00));
    directed.push_back(make_item(OP_SHUFFLE, '0, 1'b0, 8'b00_01_10_11));
    directed.push_back(make_item(OP_SHUFFLE, '0, 1'b0, 8'hff));
    directed.push_back(make_item(OP_ROLLUP, '0, 1'b0, 8'h00));
    directed.push_back(make_item(OP_ROLLDOWN, '0, 1'b0, 8'h00));
    directed.push_back(make_item(OP_SWAPXY, '0, 1'b0, 8'h00));
    directed.push_back(make_item(OP_DROP, '0, 1'b0, 8'h00));
    directed.push_back(make_item(OP_DROPY, '0, 1'b0, 8'h00));
    directed.push_back(make_item(OP_UNDO, '0, 1'b1, 8'h00));
    directed.push_back(make_item(OP_UNDO, '0, 1'b1, 8'h00));
    directed.push_back(make_item(OP_FILL, '0, 1'b0, 8'h00));
    directed.push_back(make_item(OP_CLX, '1, 1'b1, 8'hff));
    directed.push_back(make_item(OP_SPARE_FIRST, '1, 1'b1, 8'hff));
    directed.push_back(make_item(OP_SPARE_LAST, '1, 1'b1, 8'hff));
    directed.push_back(make_item(OP_CLEAR, '0, 1'b0, 8'h00));

    for (int ph = 0; ph < 4; ph++) begin
      write_depth(depth_plan[ph]);
      if (ph == 0)
        foreach (directed[i]) send_with_gap(directed[i]);
      // Starve the result side while beats keep coming, so the input stalls.
      if (ph == 1) hold_req = 1;
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (ph == 2 && k == 100) begin
          in_tvalid <= 1'b0;
          wait_drained();
        end
        if (ph == 3) send_beat(rand_item());
        else send_with_gap(rand_item());
      end
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0)
      $display("tb_rpn_operand_stack_top: done, clean");
    else
      $display("tb_rpn_operand_stack_top: done, errors");
    $finish;
  end

endmodule
